>>> rtl/ltp_pkg.sv
// Shared types, character codes and label helpers for the telemetry text parser.
`default_nettype none

package ltp_pkg;

   localparam int LABEL_BUF = 16;
   localparam int VALUE_BUF = 32;
   localparam int LABEL_CAP = LABEL_BUF - 1;
   localparam int VALUE_CAP = VALUE_BUF - 1;
   localparam int LCNT_W    = $clog2(LABEL_BUF);
   localparam int VCNT_W    = $clog2(VALUE_BUF);

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UPPER_O = 8'h4F;
   localparam logic [7:0] CH_UPPER_N = 8'h4E;

   localparam logic [31:0] SAT_MAG = 32'h8000_0000;
   localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

   // Names right aligned (last char in byte 0); label buffer starts at byte 0.
   typedef logic [7:0][7:0] name_type;
   typedef logic [LABEL_CAP-1:0][7:0] label_buf_type;

   localparam name_type NAME_CHECKSUM = "Checksum";
   localparam name_type NAME_V        = "V";
   localparam name_type NAME_I        = "I";
   localparam name_type NAME_VPV      = "VPV";
   localparam name_type NAME_PPV      = "PPV";
   localparam name_type NAME_CS       = "CS";
   localparam name_type NAME_MPPT     = "MPPT";
   localparam name_type NAME_ERR      = "ERR";
   localparam name_type NAME_H19      = "H19";
   localparam name_type NAME_H20      = "H20";
   localparam name_type NAME_H21      = "H21";
   localparam name_type NAME_LOAD     = "LOAD";

   localparam logic [LCNT_W-1:0] LEN_CHECKSUM = LCNT_W'(8);
   localparam logic [LCNT_W-1:0] LEN_1        = LCNT_W'(1);
   localparam logic [LCNT_W-1:0] LEN_2        = LCNT_W'(2);
   localparam logic [LCNT_W-1:0] LEN_3        = LCNT_W'(3);
   localparam logic [LCNT_W-1:0] LEN_4        = LCNT_W'(4);

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_LABEL = 4'b0010,
      PH_VALUE = 4'b0100,
      PH_CHECK = 4'b1000
   } parse_phase_type;

   typedef enum logic [2:0] {
      NUM_SKIP   = 3'b001,
      NUM_DIGITS = 3'b010,
      NUM_DONE   = 3'b100
   } num_phase_type;

   typedef enum logic [3:0] {
      ON_START = 4'b0001,
      ON_GOT_O = 4'b0010,
      ON_GOT_N = 4'b0100,
      ON_FAIL  = 4'b1000
   } on_match_type;

   typedef struct packed {
      logic               frame_ok;
      logic signed [31:0] battery_mv;
      logic signed [31:0] battery_ma;
      logic signed [31:0] panel_mv;
      logic [15:0]        panel_watts;
      logic [7:0]         charge_code;
      logic [7:0]         tracker_code;
      logic [7:0]         fault_code;
      logic [31:0]        total_yield_wh;
      logic [31:0]        today_yield_wh;
      logic [15:0]        peak_watts_today;
      logic               load_enabled;
   } rsp_payload_type;

   // Text ends at the first zero byte or at the stored count.
   function automatic logic label_match(label_buf_type chars, logic [LCNT_W-1:0] count,
                                        name_type name, logic [LCNT_W-1:0] len);
      logic             hit;
      logic [LCNT_W-1:0] pos;
      hit = (count >= len);
      for (int i = 0; i < 8; i++) begin
         pos = len - LCNT_W'(i) - LCNT_W'(1);
         if (LCNT_W'(i) < len && chars[i] != name[pos[2:0]]) begin
            hit = 1'b0;
         end
      end
      if (count != len && chars[len] != CH_NUL) begin
         hit = 1'b0;
      end
      return hit;
   endfunction

endpackage

`default_nettype wire

>>> rtl/ltp_req_if.sv
// Input byte channel: valid/ready handshake carrying one received byte.
`default_nettype none

interface ltp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/ltp_rsp_if.sv
// Frame record channel: valid/ready handshake carrying one parsed frame.
`default_nettype none

interface ltp_rsp_if;
   import ltp_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/labelled_text_telemetry_parser_top.sv
// Top level: byte-wise LABEL<tab>VALUE line parser emitting one record per checksum byte.
//
// Channel   Dir  Beat payload
// req_bus   in   rx_byte[7:0], one received byte
// rsp_bus   out  frame record (frame_ok, staged telemetry fields)
//
// One byte per cycle while req_bus.ready is high; the parse step is combinational from the state registers.
// A record appears in the output register the cycle after its checksum byte beat.
// req_bus.ready is low only while a record waits and rsp_bus.ready is low.
// Synchronous reset clears the phase, sum, counters and staged fields.
`default_nettype none

module labelled_text_telemetry_parser_top (
   input  wire logic clock,
   input  wire logic reset,
   ltp_req_if.sink   req_bus,
   ltp_rsp_if.source rsp_bus
);
   import ltp_pkg::*;

   parse_phase_type     phase_ff, phase_in;
   logic [7:0]          sum_ff, sum_in;
   label_buf_type       label_ff, label_in;
   logic [LCNT_W-1:0]   lcount_ff, lcount_in;
   logic [VCNT_W-1:0]   vcount_ff, vcount_in;
   logic [31:0]         accum_ff, accum_in;
   num_phase_type       nphase_ff, nphase_in;
   logic                neg_ff, neg_in;
   on_match_type        on_ff, on_in;

   logic signed [31:0]  bat_mv_ff, bat_mv_in;
   logic signed [31:0]  bat_ma_ff, bat_ma_in;
   logic signed [31:0]  pv_mv_ff, pv_mv_in;
   logic [15:0]         ppv_ff, ppv_in;
   logic [7:0]          cs_ff, cs_in;
   logic [7:0]          mppt_ff, mppt_in;
   logic [7:0]          err_ff, err_in;
   logic [31:0]         h19_ff, h19_in;
   logic [31:0]         h20_ff, h20_in;
   logic [15:0]         h21_ff, h21_in;
   logic                load_ff, load_in;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_ff, rsp_in;

   logic [7:0]          rx;
   logic                accept;
   logic                is_eol;
   logic                is_digit;
   logic                is_blank;
   logic [35:0]         prod;
   logic [31:0]         accum_next;
   logic [31:0]         num_value;
   logic [31:0]         num_x10;
   rsp_payload_type     record;

   assign rx            = req_bus.rx_byte;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;

   assign is_eol   = (rx == CH_CR) || (rx == CH_LF);
   assign is_digit = (rx >= CH_ZERO) && (rx <= CH_NINE);
   assign is_blank = (rx == CH_SPACE) || (rx == CH_TAB) || (rx == CH_VT) || (rx == CH_FF);

   // accum * 10 + digit, clamped to the magnitude of the most negative value
   assign prod       = ({4'b0, accum_ff} << 3) + ({4'b0, accum_ff} << 1) + 36'(rx[3:0]);
   assign accum_next = (prod > 36'(SAT_MAG)) ? SAT_MAG : prod[31:0];

   assign num_value = neg_ff ? (32'd0 - accum_ff) : (accum_ff[31] ? POS_MAX : accum_ff);
   assign num_x10   = (num_value << 3) + (num_value << 1);

   always_comb begin
      record.frame_ok         = ((sum_ff + rx) == 8'd0);
      record.battery_mv       = bat_mv_ff;
      record.battery_ma       = bat_ma_ff;
      record.panel_mv         = pv_mv_ff;
      record.panel_watts      = ppv_ff;
      record.charge_code      = cs_ff;
      record.tracker_code     = mppt_ff;
      record.fault_code       = err_ff;
      record.total_yield_wh   = h19_ff;
      record.today_yield_wh   = h20_ff;
      record.peak_watts_today = h21_ff;
      record.load_enabled     = load_ff;
   end

   always_comb begin
      phase_in     = phase_ff;
      sum_in       = sum_ff;
      label_in     = label_ff;
      lcount_in    = lcount_ff;
      vcount_in    = vcount_ff;
      accum_in     = accum_ff;
      nphase_in    = nphase_ff;
      neg_in       = neg_ff;
      on_in        = on_ff;
      bat_mv_in    = bat_mv_ff;
      bat_ma_in    = bat_ma_ff;
      pv_mv_in     = pv_mv_ff;
      ppv_in       = ppv_ff;
      cs_in        = cs_ff;
      mppt_in      = mppt_ff;
      err_in       = err_ff;
      h19_in       = h19_ff;
      h20_in       = h20_ff;
      h21_in       = h21_ff;
      load_in      = load_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      if (accept) begin
         sum_in = sum_ff + rx;
         case (phase_ff)
            PH_IDLE: begin
               if (!is_eol) begin
                  label_in[0] = rx;
                  lcount_in   = LCNT_W'(1);
                  phase_in    = PH_LABEL;
               end
            end
            PH_LABEL: begin
               if (rx == CH_TAB) begin
                  vcount_in = '0;
                  accum_in  = '0;
                  nphase_in = NUM_SKIP;
                  neg_in    = 1'b0;
                  on_in     = ON_START;
                  phase_in  = label_match(label_ff, lcount_ff, NAME_CHECKSUM, LEN_CHECKSUM)
                              ? PH_CHECK : PH_VALUE;
               end else if (lcount_ff < LCNT_W'(LABEL_CAP)) begin
                  label_in[lcount_ff] = rx;
                  lcount_in           = lcount_ff + LCNT_W'(1);
               end
            end
            PH_VALUE: begin
               if (is_eol) begin
                  phase_in = PH_IDLE;
                  if (label_match(label_ff, lcount_ff, NAME_V, LEN_1)) bat_mv_in = num_value;
                  else if (label_match(label_ff, lcount_ff, NAME_I, LEN_1)) bat_ma_in = num_value;
                  else if (label_match(label_ff, lcount_ff, NAME_VPV, LEN_3)) pv_mv_in = num_value;
                  else if (label_match(label_ff, lcount_ff, NAME_PPV, LEN_3)) ppv_in = num_value[15:0];
                  else if (label_match(label_ff, lcount_ff, NAME_CS, LEN_2)) cs_in = num_value[7:0];
                  else if (label_match(label_ff, lcount_ff, NAME_MPPT, LEN_4)) mppt_in = num_value[7:0];
                  else if (label_match(label_ff, lcount_ff, NAME_ERR, LEN_3)) err_in = num_value[7:0];
                  else if (label_match(label_ff, lcount_ff, NAME_H19, LEN_3)) h19_in = num_x10;
                  else if (label_match(label_ff, lcount_ff, NAME_H20, LEN_3)) h20_in = num_x10;
                  else if (label_match(label_ff, lcount_ff, NAME_H21, LEN_3)) h21_in = num_value[15:0];
                  else if (label_match(label_ff, lcount_ff, NAME_LOAD, LEN_4)) load_in = (on_ff == ON_GOT_N);
               end else if (vcount_ff < VCNT_W'(VALUE_CAP)) begin
                  if (rx == CH_NUL) begin
                     // zero byte ends the value text
                     vcount_in = VCNT_W'(VALUE_CAP);
                  end else begin
                     vcount_in = vcount_ff + VCNT_W'(1);
                     case (nphase_ff)
                        NUM_SKIP: begin
                           if (is_blank) begin
                              nphase_in = NUM_SKIP;
                           end else if (rx == CH_PLUS || rx == CH_MINUS) begin
                              neg_in    = (rx == CH_MINUS);
                              nphase_in = NUM_DIGITS;
                           end else if (is_digit) begin
                              nphase_in = NUM_DIGITS;
                              accum_in  = accum_next;
                           end else begin
                              nphase_in = NUM_DONE;
                           end
                        end
                        NUM_DIGITS: begin
                           if (is_digit) accum_in = accum_next;
                           else nphase_in = NUM_DONE;
                        end
                        default: nphase_in = NUM_DONE;
                     endcase
                     case (on_ff)
                        ON_START: on_in = (rx == CH_UPPER_O) ? ON_GOT_O : ON_FAIL;
                        ON_GOT_O: on_in = (rx == CH_UPPER_N) ? ON_GOT_N : ON_FAIL;
                        default:  on_in = ON_FAIL;
                     endcase
                  end
               end
            end
            PH_CHECK: begin
               rsp_in       = record;
               rsp_valid_in = 1'b1;
               sum_in       = '0;
               phase_in     = PH_IDLE;
               bat_mv_in    = '0;
               bat_ma_in    = '0;
               pv_mv_in     = '0;
               ppv_in       = '0;
               cs_in        = '0;
               mppt_in      = '0;
               err_in       = '0;
               h19_in       = '0;
               h20_in       = '0;
               h21_in       = '0;
               load_in      = 1'b0;
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         sum_ff       <= '0;
         lcount_ff    <= '0;
         vcount_ff    <= '0;
         accum_ff     <= '0;
         nphase_ff    <= NUM_SKIP;
         neg_ff       <= 1'b0;
         on_ff        <= ON_START;
         bat_mv_ff    <= '0;
         bat_ma_ff    <= '0;
         pv_mv_ff     <= '0;
         ppv_ff       <= '0;
         cs_ff        <= '0;
         mppt_ff      <= '0;
         err_ff       <= '0;
         h19_ff       <= '0;
         h20_ff       <= '0;
         h21_ff       <= '0;
         load_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         sum_ff       <= sum_in;
         lcount_ff    <= lcount_in;
         vcount_ff    <= vcount_in;
         accum_ff     <= accum_in;
         nphase_ff    <= nphase_in;
         neg_ff       <= neg_in;
         on_ff        <= on_in;
         bat_mv_ff    <= bat_mv_in;
         bat_ma_ff    <= bat_ma_in;
         pv_mv_ff     <= pv_mv_in;
         ppv_ff       <= ppv_in;
         cs_ff        <= cs_in;
         mppt_ff      <= mppt_in;
         err_ff       <= err_in;
         h19_ff       <= h19_in;
         h20_ff       <= h20_in;
         h21_ff       <= h21_in;
         load_ff      <= load_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      label_ff <= label_in;
      rsp_ff   <= rsp_in;
   end

endmodule

`default_nettype wire
